### rtl/core/csrc_pkg.sv
package csrc_pkg;

  // Default disk geometry and descriptor table size.
  localparam int unsigned SectorsPerTrackDef = 18;
  localparam int unsigned HeadCountDef       = 2;
  localparam int unsigned CylinderCountDef   = 80;
  localparam int unsigned MaxRunsDef         = 30;

  // Field widths of the stream payloads.
  localparam int unsigned SnW    = 12;  // absolute sector number
  localparam int unsigned CylW   = 7;   // cylinder
  localparam int unsigned SecW   = 6;   // one-based sector inside the unit (up to 63)
  localparam int unsigned FieldW = 5;   // start, count and index fields of a result
  localparam int unsigned NumW   = 6;   // descriptors booked in the table

  // A run never grows beyond what the count field can hold.
  localparam logic [FieldW-1:0] LenLimit = '1;

  // Entries of the queue between the front and the back; a power of two.
  localparam int unsigned QueueDepth = 4;

  // One converted sector as handed from the front to the back.
  typedef struct packed {
    logic [CylW-1:0] cylinder;
    logic            head;
    logic [SecW-1:0] sector;
    logic            out_of_range;
    logic            final_req;
  } csrc_item_t;

  // One read descriptor or range flag as delivered on the output stream.
  typedef struct packed {
    logic [CylW-1:0]   cylinder;
    logic              head;
    logic [FieldW-1:0] start_sector;
    logic [FieldW-1:0] sector_count;
    logic [FieldW-1:0] run_index;
    logic              table_full;
    logic              out_of_range;
    logic              last;
  } csrc_result_t;

endpackage

### rtl/core/csrc_front.sv
module csrc_front
  import csrc_pkg::*;
#(
  parameter int unsigned SECTORS_PER_TRACK = SectorsPerTrackDef,
  parameter int unsigned HEAD_COUNT        = HeadCountDef,
  parameter int unsigned CYLINDER_COUNT    = CylinderCountDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [SnW-1:0]   sector_number_i,
  input  logic             final_req_i,
  output logic             push_o,
  output csrc_item_t       item_o,
  input  logic             full_i
);

  // Exact division by the track length: multiply by a rounded-up reciprocal.
  localparam int unsigned RecipShift = SnW + $clog2(SECTORS_PER_TRACK);
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam int unsigned RecipVal   =
      ((2 ** RecipShift) + SECTORS_PER_TRACK - 1) / SECTORS_PER_TRACK;
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipVal);
  localparam int unsigned ProdW = SnW + RecipW;

  logic               s1_valid_q;
  logic [SnW-1:0]     s1_sn_q;
  logic               s1_fin_q;
  logic [ProdW-1:0]   s1_prod_q;

  logic               accept;
  logic [SnW-1:0]     track;
  logic [SnW-1:0]     track_base;
  logic [SecW-1:0]    remainder;
  logic [SnW-1:0]     cyl_full;
  logic               head;

  assign in_ready_o = !s1_valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = s1_valid_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (push_o) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sn_q   <= sector_number_i;
      s1_fin_q  <= final_req_i;
      s1_prod_q <= ProdW'(sector_number_i) * ProdW'(Recip);
    end
  end

  always_comb begin
    track      = s1_prod_q[RecipShift +: SnW];
    track_base = SnW'(track * SnW'(SECTORS_PER_TRACK));
    remainder  = SecW'(s1_sn_q - track_base);
    if (HEAD_COUNT == 2) begin
      head     = track[0];
      cyl_full = track >> 1;
    end else begin
      head     = 1'b0;
      cyl_full = track;
    end
    item_o.cylinder     = cyl_full[CylW-1:0];
    item_o.head         = head;
    item_o.sector       = remainder + SecW'(1);
    item_o.out_of_range = cyl_full >= SnW'(CYLINDER_COUNT);
    item_o.final_req    = s1_fin_q;
  end

endmodule

### rtl/core/csrc_fifo.sv
module csrc_fifo
  import csrc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  csrc_item_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output csrc_item_t data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  csrc_item_t        mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o  = count_q == CntW'(QueueDepth);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/core/csrc_back.sv
module csrc_back
  import csrc_pkg::*;
#(
  parameter int unsigned MAX_RUNS = MaxRunsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         item_valid_i,
  input  csrc_item_t   item_i,
  output logic         pop_o,
  output logic         out_valid_o,
  output csrc_result_t out_o,
  input  logic         out_ready_i
);

  logic              run_open_q;
  logic [CylW-1:0]   run_cyl_q;
  logic              run_head_q;
  logic [FieldW-1:0] run_start_q;
  logic [FieldW-1:0] run_len_q;
  logic [NumW-1:0]   run_num_q;

  logic              out_valid_q;
  csrc_result_t      out_q;
  logic              pend_valid_q;
  csrc_result_t      pend_q;

  logic              nxt_open;
  logic [CylW-1:0]   nxt_cyl;
  logic              nxt_head;
  logic [FieldW-1:0] nxt_start;
  logic [FieldW-1:0] nxt_len;
  logic [NumW-1:0]   nxt_num;
  csrc_result_t      res0;
  csrc_result_t      res1;
  csrc_result_t      flush;
  logic [1:0]        n_res;
  logic              extend;
  logic              out_take;

  // Descriptor of the open run; a full table yields a dropped entry at index zero.
  function automatic csrc_result_t make_run(logic [CylW-1:0] cyl, logic hd,
                                            logic [FieldW-1:0] st,
                                            logic [FieldW-1:0] len,
                                            logic [NumW-1:0] num);
    csrc_result_t r;
    r              = '0;
    r.cylinder     = cyl;
    r.head         = hd;
    r.start_sector = st;
    r.sector_count = len;
    r.table_full   = num >= NumW'(MAX_RUNS);
    r.run_index    = r.table_full ? '0 : num[FieldW-1:0];
    return r;
  endfunction

  assign out_take = out_valid_q && out_ready_i;
  assign pop_o    = item_valid_i && !pend_valid_q && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign extend = run_open_q && (item_i.sector == SecW'(run_start_q) + SecW'(run_len_q))
                  && (item_i.head == run_head_q) && (item_i.cylinder == run_cyl_q)
                  && (run_len_q < LenLimit);

  always_comb begin
    nxt_open  = run_open_q;
    nxt_cyl   = run_cyl_q;
    nxt_head  = run_head_q;
    nxt_start = run_start_q;
    nxt_len   = run_len_q;
    nxt_num   = run_num_q;
    res0      = '0;
    res1      = '0;
    flush     = '0;
    n_res     = 2'd0;

    if (item_i.out_of_range) begin
      res0.out_of_range = 1'b1;
      n_res             = 2'd1;
    end else if (extend) begin
      nxt_len = run_len_q + FieldW'(1);
    end else begin
      if (run_open_q) begin
        res0  = make_run(run_cyl_q, run_head_q, run_start_q, run_len_q, run_num_q);
        n_res = 2'd1;
        if (!res0.table_full) begin
          nxt_num = run_num_q + NumW'(1);
        end
      end
      nxt_open  = 1'b1;
      nxt_cyl   = item_i.cylinder;
      nxt_head  = item_i.head;
      nxt_start = item_i.sector[FieldW-1:0];
      nxt_len   = FieldW'(1);
    end

    if (item_i.final_req) begin
      if (nxt_open) begin
        flush = make_run(nxt_cyl, nxt_head, nxt_start, nxt_len, nxt_num);
        if (n_res == 2'd0) begin
          res0 = flush;
        end else begin
          res1 = flush;
        end
        n_res = n_res + 2'd1;
      end
      if (n_res == 2'd2) begin
        res1.last = 1'b1;
      end else begin
        res0.last = 1'b1;
      end
      nxt_open  = 1'b0;
      nxt_cyl   = '0;
      nxt_head  = 1'b0;
      nxt_start = '0;
      nxt_len   = '0;
      nxt_num   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q   <= 1'b0;
      run_cyl_q    <= '0;
      run_head_q   <= 1'b0;
      run_start_q  <= '0;
      run_len_q    <= '0;
      run_num_q    <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        run_open_q  <= nxt_open;
        run_cyl_q   <= nxt_cyl;
        run_head_q  <= nxt_head;
        run_start_q <= nxt_start;
        run_len_q   <= nxt_len;
        run_num_q   <= nxt_num;
      end
      if (pend_valid_q) begin
        if (out_take) begin
          pend_valid_q <= 1'b0;
        end
      end else if (pop_o && n_res != 2'd0) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= n_res == 2'd2;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_valid_q) begin
      if (out_take) begin
        out_q <= pend_q;
      end
    end else if (pop_o && n_res != 2'd0) begin
      out_q  <= res0;
      pend_q <= res1;
    end
  end

endmodule

### rtl/core/chs_sector_run_coalescer.sv
// Path: a sector number passes the front stage register, the queue and the output register.
// Throughput: one transaction per cycle in unless the queue is full; an item with two results
// (a closed run or a range flag, plus a flush) stops further pops until the second is taken.
// Reset: rst_ni is asynchronous and active low; it empties the queue and output stages and
// returns the open run and the table count to zero. No clearing pass follows reset.
module chs_sector_run_coalescer
  import csrc_pkg::*;
#(
  parameter int unsigned SECTORS_PER_TRACK = SectorsPerTrackDef,
  parameter int unsigned HEAD_COUNT        = HeadCountDef,
  parameter int unsigned CYLINDER_COUNT    = CylinderCountDef,
  parameter int unsigned MAX_RUNS          = MaxRunsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave side: one absolute sector number per transaction.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] sector_number, [15:12] zero
  input  logic        s_axis_tlast,   // final_req
  // Master side: one read descriptor or range flag per transaction.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [6:0] cylinder, [7] head, [12:8] start_sector,
                                      // [17:13] sector_count, [22:18] run_index, [23] zero
  output logic [1:0]  m_axis_tuser,   // [0] table_full, [1] out_of_range
  output logic        m_axis_tlast    // last
);

  // The front end converts each sector number to cylinder, head and sector with
  // a reciprocal multiply, registered before the remainder is formed, and flags
  // sectors past the last cylinder. The converted items wait in a short queue,
  // so the input side keeps accepting while the output is stalled, until the queue fills.
  // The back end holds the open run and decides, per item, whether it extends
  // the run or closes it. Up to two results per item leave through an output
  // register and a one-entry holding register for the second result.

  logic         push;
  logic         pop;
  logic         q_full;
  logic         q_valid;
  csrc_item_t   push_item;
  csrc_item_t   pop_item;
  csrc_result_t result;

  csrc_front #(
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
    .HEAD_COUNT        (HEAD_COUNT),
    .CYLINDER_COUNT    (CYLINDER_COUNT)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .sector_number_i (s_axis_tdata[SnW-1:0]),
    .final_req_i     (s_axis_tlast),
    .push_o          (push),
    .item_o          (push_item),
    .full_i          (q_full)
  );

  csrc_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pop_item)
  );

  csrc_back #(
    .MAX_RUNS (MAX_RUNS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (pop_item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_o        (result),
    .out_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, result.run_index, result.sector_count, result.start_sector,
                         result.head, result.cylinder};
  assign m_axis_tuser = {result.out_of_range, result.table_full};
  assign m_axis_tlast = result.last;

endmodule

### rtl/core/csrc_checker.sv
module csrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result holds its payload until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  // A range flag carries no descriptor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 24'd0 && !m_axis_tuser[0])
    else $error("range flag with descriptor fields set");

  // A dropped descriptor sits at index zero, and every descriptor covers a sector.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |->
      m_axis_tdata[17:13] != 5'd0 && (!m_axis_tuser[0] || m_axis_tdata[22:18] == 5'd0))
    else $error("malformed run descriptor");

endmodule

bind chs_sector_run_coalescer csrc_checker u_csrc_checker (.*);
